/* design/palette_gradient_sampler_assert.svh */
// Assertion macros for the palette gradient sampler RTL.
`ifndef PALETTE_GRADIENT_SAMPLER_ASSERT_SVH
`define PALETTE_GRADIENT_SAMPLER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PGS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/pgs_pkg.sv */
// Types, constants and helper functions for the palette gradient sampler.
package pgs_pkg;

	localparam int COUNT_W = 3;
	localparam int WORD_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Register index of the stop count; stop words follow from index 1.
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_WORD_0 = 3'd1;

	localparam logic [7:0]  FULL_SCALE = 8'd255;
	// ceil(2^23 / 255): exact x/255 for any 16-bit x via (x*RECIP_255) >> 23
	localparam logic [15:0] RECIP_255 = 16'h8081;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Stop pair chosen for one position
	typedef struct packed {
		rgb_t       left;
		rgb_t       right;
		logic [7:0] delta;
		logic [7:0] span;
	} sel_t;

	// Division state carried through the divider stages
	typedef struct packed {
		rgb_t       left;
		rgb_t       right;
		logic [7:0] divisor;
		logic [7:0] rem;
		logic [7:0] low;
		logic [7:0] quot;
	} divw_t;

	// One restoring division step: brings in the next dividend bit
	function automatic divw_t pgs_div_step(input divw_t x);
		divw_t      y;
		logic [8:0] trial;
		logic       qbit;
		y = x;
		trial = {x.rem, x.low[7]};
		qbit = (trial >= {1'b0, x.divisor});
		if (qbit) begin
			y.rem = 8'(trial - {1'b0, x.divisor});
		end else begin
			y.rem = trial[7:0];
		end
		y.low = {x.low[6:0], 1'b0};
		y.quot = {x.quot[6:0], qbit};
		return y;
	endfunction

endpackage

/* design/palette_gradient_sampler.sv */
// Palette gradient sampler: one RGB beat out for each position beat in.
// Stages in order: stop select, four divider stages, weighting, scaling.
// Throughput one beat per cycle; the whole pipe holds while the output stalls.
// Reset clears stop count, stop words and all stage valid bits; data regs are not reset.
`include "palette_gradient_sampler_assert.svh"
module palette_gradient_sampler import pgs_pkg::*; #(
	parameter int MAX_STOPS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] position
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [COUNT_W-1:0] n_stops_q;
	logic [WORD_W-1:0]  stop_word_q [MAX_STOPS];
	logic               en;
	logic               sel_valid;
	sel_t               sel;
	logic               div_valid;
	divw_t              div;
	rgb_t               rgb;

	// Pipeline advances unless the output beat is held
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// Configuration registers; count saturates at the stop capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_stops_q <= '0;
			for (int i = 0; i < MAX_STOPS; i++) begin
				stop_word_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_STOP_COUNT) begin
				if (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_STOPS)) begin
					n_stops_q <= COUNT_W'(MAX_STOPS);
				end else begin
					n_stops_q <= cfg_data[COUNT_W-1:0];
				end
			end
			for (int i = 0; i < MAX_STOPS; i++) begin
				if (cfg_index == REG_STOP_WORD_0 + CFG_IDX_W'(i)) begin
					stop_word_q[i] <= cfg_data;
				end
			end
		end
	end

	pgs_select #(
		.MAX_STOPS(MAX_STOPS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pos       (s_tdata),
		.n_stops   (n_stops_q),
		.stop_words(stop_word_q),
		.valid_s1  (sel_valid),
		.sel_s1    (sel)
	);

	pgs_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(sel_valid),
		.in_sel  (sel),
		.valid_s5(div_valid),
		.div_s5  (div)
	);

	pgs_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(div_valid),
		.in_div  (div),
		.valid_s7(m_tvalid),
		.rgb_s7  (rgb)
	);

	assign m_tdata = {rgb.blue, rgb.green, rgb.red};

	// Checks
	`PGS_ASSERT_ALWAYS(a_count_sat, n_stops_q <= COUNT_W'(MAX_STOPS), "stop count above capacity")
	`PGS_ASSERT_ALWAYS(a_span_nonzero, !sel_valid || sel.span != 8'd0, "zero divisor in stage 1")
	`PGS_ASSERT_NEXT(a_accept_s1, s_tvalid && s_tready, sel_valid, "accepted beat lost at stage 1")

endmodule

/* design/pgs_select.sv */
// Stage 1: picks the bracketing stops and forms distance and span.
module pgs_select import pgs_pkg::*; #(
	parameter int MAX_STOPS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [7:0]         pos,
	input  logic [COUNT_W-1:0] n_stops,
	input  logic [WORD_W-1:0]  stop_words [MAX_STOPS],
	output logic               valid_s1,
	output sel_t               sel_s1
);

	sel_t sel_d;

	// Scan for the first stop from 1 upward whose position is at or above pos
	always_comb begin
		logic [WORD_W-1:0] first_w;
		logic [WORD_W-1:0] last_w;
		logic [WORD_W-1:0] lw;
		logic [WORD_W-1:0] rw;
		first_w = stop_words[0];
		last_w = first_w;
		lw = first_w;
		rw = first_w;
		for (int k = 0; k < MAX_STOPS; k++) begin
			if (COUNT_W'(k + 1) == n_stops) begin
				last_w = stop_words[k];
			end
		end
		// descending so the lowest matching stop wins
		for (int k = MAX_STOPS - 1; k >= 1; k--) begin
			if (COUNT_W'(k) < n_stops && pos <= stop_words[k][31:24]) begin
				lw = stop_words[k-1];
				rw = stop_words[k];
			end
		end
		// direct colours pass as left with zero progress
		sel_d.left = '0;
		sel_d.right = '0;
		sel_d.delta = 8'd0;
		sel_d.span = 8'd1;
		if (n_stops == COUNT_W'(0)) begin
			sel_d.left = '0;
		end else if (n_stops == COUNT_W'(1) || pos <= first_w[31:24]) begin
			sel_d.left = rgb_t'(first_w[23:0]);
		end else if (pos >= last_w[31:24]) begin
			sel_d.left = rgb_t'(last_w[23:0]);
		end else begin
			sel_d.left = rgb_t'(lw[23:0]);
			sel_d.right = rgb_t'(rw[23:0]);
			sel_d.delta = pos - lw[31:24];
			sel_d.span = rw[31:24] - lw[31:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel_d;
		end
	end

endmodule

/* design/pgs_divider.sv */
// Stages 2 to 5: progress = delta*255/span, two quotient bits per stage.
module pgs_divider import pgs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  sel_t  in_sel,
	output logic  valid_s5,
	output divw_t div_s5
);

	logic [15:0] dividend;
	divw_t       init;
	logic        valid_s2, valid_s3, valid_s4;
	divw_t       div_s2, div_s3, div_s4;

	// delta*255 < span*256, so the top byte is already below the divisor
	always_comb begin
		dividend = {in_sel.delta, 8'd0} - {8'd0, in_sel.delta};
		init.left = in_sel.left;
		init.right = in_sel.right;
		init.divisor = in_sel.span;
		init.rem = dividend[15:8];
		init.low = dividend[7:0];
		init.quot = 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= pgs_div_step(pgs_div_step(init));
			div_s3 <= pgs_div_step(pgs_div_step(div_s2));
			div_s4 <= pgs_div_step(pgs_div_step(div_s3));
			div_s5 <= pgs_div_step(pgs_div_step(div_s4));
		end
	end

endmodule

/* design/pgs_blend.sv */
// Stages 6 and 7: weight both colours by progress and divide by 255.
module pgs_blend import pgs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  divw_t in_div,
	output logic  valid_s7,
	output rgb_t  rgb_s7
);

	logic [7:0]  l_ch [3];
	logic [7:0]  r_ch [3];
	logic [7:0]  inv_p;
	logic        valid_s6;
	logic [15:0] prod_l_s6 [3];
	logic [15:0] prod_r_s6 [3];
	logic [15:0] sum [3];
	logic [31:0] scaled [3];
	rgb_t        rgb_d;

	always_comb begin
		l_ch[0] = in_div.left.red;
		l_ch[1] = in_div.left.green;
		l_ch[2] = in_div.left.blue;
		r_ch[0] = in_div.right.red;
		r_ch[1] = in_div.right.green;
		r_ch[2] = in_div.right.blue;
		inv_p = FULL_SCALE - in_div.quot;
	end

	// Sum stays at or below 255*255; reciprocal multiply gives exact /255
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = prod_l_s6[c] + prod_r_s6[c];
			scaled[c] = 32'(sum[c]) * 32'(RECIP_255);
		end
		rgb_d.red = scaled[0][30:23];
		rgb_d.green = scaled[1][30:23];
		rgb_d.blue = scaled[2][30:23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s6 <= in_valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				prod_l_s6[c] <= 16'(l_ch[c]) * 16'(inv_p);
				prod_r_s6[c] <= 16'(r_ch[c]) * 16'(in_div.quot);
			end
			rgb_s7 <= rgb_d;
		end
	end

endmodule
